>>> hw/rtl/div64_pkg.sv
// ----------------------------------------------------------------------------
// div64_pkg
// Types and constants shared by the pipelined 64-bit divider.
// ----------------------------------------------------------------------------
`default_nettype none

package div64_pkg;

    localparam int unsigned DataW = 64;

    typedef logic [DataW-1:0] word_t;

    localparam word_t MostNeg  = 64'h8000_0000_0000_0000;
    localparam word_t AllOnes  = 64'hFFFF_FFFF_FFFF_FFFF;

    // Work carried between pipeline stages (valid travels beside it)
    typedef struct packed {
        logic  negate;   // quotient must be negated at the end
        logic  dbz;      // divisor was zero
        logic  ovf;      // signed most-negative by minus one
        word_t den;      // divisor magnitude
        word_t rem;      // partial remainder
        word_t acc;      // dividend bits shifting out, quotient bits shifting in
    } stage_t;

    // One finished result
    typedef struct packed {
        word_t quotient;
        logic  ovf;
        logic  dbz;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/div64_pre.sv
// ----------------------------------------------------------------------------
// div64_pre
// Input stage: take operand magnitudes and flag the special cases.
// ----------------------------------------------------------------------------
`default_nettype none

module div64_pre (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic              mode,
    input  wire div64_pkg::word_t  dividend,
    input  wire div64_pkg::word_t  divisor,
    output logic                   out_valid,
    output div64_pkg::stage_t      out_stage
);

    logic              valid_reg;
    div64_pkg::stage_t stage_reg;
    div64_pkg::stage_t stage_next;
    div64_pkg::word_t  num_mag;
    div64_pkg::word_t  den_mag;
    logic              num_neg;
    logic              den_neg;

    always_comb
    begin
        num_neg = mode & dividend[div64_pkg::DataW-1];
        den_neg = mode & divisor[div64_pkg::DataW-1];
        num_mag = num_neg ? (~dividend + div64_pkg::word_t'(1)) : dividend;
        den_mag = den_neg ? (~divisor + div64_pkg::word_t'(1)) : divisor;

        stage_next.negate = num_neg ^ den_neg;
        stage_next.dbz    = (divisor == '0);
        stage_next.ovf    = mode && (dividend == div64_pkg::MostNeg)
                                 && (divisor == div64_pkg::AllOnes);
        stage_next.den    = den_mag;
        stage_next.rem    = '0;
        stage_next.acc    = num_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

`default_nettype wire

>>> hw/rtl/div64_step.sv
// ----------------------------------------------------------------------------
// div64_step
// One restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module div64_step (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire div64_pkg::stage_t in_stage,
    output logic                   out_valid,
    output div64_pkg::stage_t      out_stage
);

    localparam int unsigned W = div64_pkg::DataW;

    logic              valid_reg;
    div64_pkg::stage_t stage_reg;
    div64_pkg::stage_t stage_next;
    logic [W:0]        trial;
    logic [W:0]        diff;
    logic              take;

    always_comb
    begin
        // shift next dividend bit into the remainder, try to subtract
        trial = {in_stage.rem, in_stage.acc[W-1]};
        diff  = trial - {1'b0, in_stage.den};
        take  = ~diff[W];

        stage_next     = in_stage;
        stage_next.rem = take ? diff[W-1:0] : trial[W-1:0];
        stage_next.acc = {in_stage.acc[W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

`default_nettype wire

>>> hw/rtl/div64_post.sv
// ----------------------------------------------------------------------------
// div64_post
// Output stage: fix the quotient sign, apply special cases, hold a skid slot.
// ----------------------------------------------------------------------------
`default_nettype none

module div64_post (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire div64_pkg::stage_t in_stage,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output div64_pkg::result_t     m_result,
    output logic                   en
);

    logic               out_valid_reg;
    div64_pkg::result_t out_reg;
    div64_pkg::result_t out_next;
    logic               skid_full_reg;
    logic               skid_full_next;
    div64_pkg::result_t skid_reg;

    always_comb
    begin
        if (in_stage.dbz)
        begin
            out_next.quotient = div64_pkg::AllOnes;
        end
        else if (in_stage.negate)
        begin
            out_next.quotient = ~in_stage.acc + div64_pkg::word_t'(1);
        end
        else
        begin
            out_next.quotient = in_stage.acc;
        end
        out_next.dbz = in_stage.dbz;
        out_next.ovf = in_stage.ovf;
    end

    // advance the pipeline whenever the skid slot is free
    assign en = ~skid_full_reg;

    always_comb
    begin
        skid_full_next = skid_full_reg;
        if (skid_full_reg)
        begin
            if (m_tready)
            begin
                skid_full_next = 1'b0;
            end
        end
        else if (out_valid_reg && !m_tready)
        begin
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
            if (en)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
        if (!skid_full_reg)
        begin
            skid_reg <= out_reg;
        end
    end

    assign m_tvalid = skid_full_reg | out_valid_reg;
    assign m_result = skid_full_reg ? skid_reg : out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/divide_64_signed_unsigned_core.sv
// ----------------------------------------------------------------------------
// divide_64_signed_unsigned_core
// Fully pipelined 64-bit signed/unsigned integer divider, one transfer a cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: s_tdata carries dividend (bits 63:0) and divisor
//   (bits 127:64); s_tuser[0] is the mode, 0 unsigned, 1 signed.
//   Output channel m_*: m_tdata is the quotient, truncated toward zero;
//   m_tuser[0] flags divide by zero (quotient all ones), m_tuser[1] flags
//   the signed most-negative by minus one case (quotient wraps to the most
//   negative value).
//   Pipeline: one input stage for sign handling, 64 restoring stages producing
//   one quotient bit each through a 65-bit subtract, and one output stage for
//   the sign fix. Throughput: one transfer per cycle while the skid slot is
//   empty, set by the one-bit-per-stage chain.
//   Stall: when m_tready drops, the waiting result moves into a skid slot
//   and the pipeline advances once more, so s_tready falls in the next cycle;
//   nothing is lost or repeated, and the pipeline resumes as the slot drains.
//   Reset: rst_n clears all valid bits; the pipeline comes up empty and
//   ready.
// ----------------------------------------------------------------------------
`default_nettype none

module divide_64_signed_unsigned_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [127:0]  s_tdata,   // dividend[63:0], divisor[127:64]
    input  wire logic [0:0]    s_tuser,   // mode[0]
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [63:0]        m_tdata,   // quotient[63:0]
    output logic [1:0]         m_tuser    // divide_by_zero[0], signed_overflow[1]
);

    localparam int unsigned Steps = div64_pkg::DataW;

    logic                en;
    logic                pipe_valid [Steps+1];
    div64_pkg::stage_t   pipe_stage [Steps+1];
    div64_pkg::result_t  result;

    // hold the input while the skid slot is occupied
    assign s_tready = en;

    div64_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .mode      (s_tuser[0]),
        .dividend  (s_tdata[63:0]),
        .divisor   (s_tdata[127:64]),
        .out_valid (pipe_valid[0]),
        .out_stage (pipe_stage[0])
    );

    // one quotient bit per stage, most significant first
    for (genvar i = 0; i < Steps; i++)
    begin : g_step
        div64_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (pipe_valid[i]),
            .in_stage  (pipe_stage[i]),
            .out_valid (pipe_valid[i+1]),
            .out_stage (pipe_stage[i+1])
        );
    end

    div64_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pipe_valid[Steps]),
        .in_stage (pipe_stage[Steps]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_result (result),
        .en       (en)
    );

    assign m_tdata = result.quotient;
    assign m_tuser = {result.ovf, result.dbz};

endmodule

`default_nettype wire
